// ----- hdl/word_token_extractor_macros.svh -----
// Assertion macros used by the word token extractor sequencer RTL.
`ifndef WORD_TOKEN_EXTRACTOR_MACROS_SVH
`define WORD_TOKEN_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/wte_pkg.sv -----
// Types, constants and byte classification for the word token extractor.
package wte_pkg;

    localparam logic [7:0] APOSTROPHE = 8'h27;

    typedef enum logic [1:0] {
        CLS_ADD,
        CLS_DUMP,
        CLS_END
    } cls_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Control from the sequencer to the row of character cells.
    typedef struct packed {
        logic       append;
        logic       shift;
        logic [7:0] wr_char;
    } chain_ctl_t;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // Classify a byte that is already folded to lower case.
    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        if ((c >= 8'h61 && c <= 8'h7A) || c == APOSTROPHE)
        begin
            r = CLS_ADD;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r = CLS_DUMP;
        end
        else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
        begin
            r = CLS_END;
        end
        else if (c >= 8'h21 && c <= 8'h7E)
        begin
            r = CLS_END;
        end
        else
        begin
            r = CLS_DUMP;
        end
        return r;
    endfunction

endpackage

// ----- hdl/wte_cell.sv -----
// One character cell of the word buffer chain.
module wte_cell #(
    parameter int CW  = 6,
    parameter int IDX = 0
) (
    input  logic                clk,
    input  wte_pkg::chain_ctl_t ctl,
    input  logic [CW-1:0]       count,
    input  logic [7:0]          nb_char,
    output logic [7:0]          char_q
);

    logic [7:0] char_reg;

    // Loaded when this cell is the next free slot; shifts toward the head on emit.
    always_ff @(posedge clk)
    begin
        if (ctl.append && count == CW'(IDX))
        begin
            char_reg <= ctl.wr_char;
        end
        else if (ctl.shift)
        begin
            char_reg <= nb_char;
        end
    end

    assign char_q = char_reg;

endmodule

// ----- hdl/wte_ctrl.sv -----
// Sequencer: classifies input bytes, tracks word length and drives the output register.
`include "word_token_extractor_macros.svh"

module wte_ctrl #(
    parameter int MAX_WORD = 32,
    parameter int CW       = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                end_of_input,
    input  logic [7:0]          head_char,
    output wte_pkg::chain_ctl_t ctl,
    output logic [CW-1:0]       count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          word_char,
    output logic                last_char,
    output logic                truncated
);

    wte_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic            ovf_reg, ovf_next;
    logic            trunc_b_reg, trunc_b_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      char_reg, char_next;
    logic            last_reg, last_next;
    logic            trunc_reg, trunc_next;

    logic            in_fire;
    logic            slot_free;
    logic [7:0]      folded;
    wte_pkg::cls_t   cls;

    assign in_ready  = (state_reg == wte_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign folded    = wte_pkg::fold_lower(in_byte);
    assign cls       = wte_pkg::classify(folded);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wte_pkg::ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            ovf_reg       <= 1'b0;
            trunc_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            ovf_reg       <= ovf_next;
            trunc_b_reg   <= trunc_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        last_reg  <= last_next;
        trunc_reg <= trunc_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        ovf_next       = ovf_reg;
        trunc_b_next   = trunc_b_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        trunc_next     = trunc_reg;
        ctl.append     = 1'b0;
        ctl.shift      = 1'b0;
        ctl.wr_char    = folded;

        unique case (state_reg)
            wte_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (end_of_input || cls == wte_pkg::CLS_END)
                    begin
                        if (count_reg != '0)
                        begin
                            state_next   = wte_pkg::ST_EMIT;
                            rem_next     = count_reg;
                            trunc_b_next = ovf_reg;
                        end
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else if (cls == wte_pkg::CLS_ADD)
                    begin
                        if (count_reg != CW'(MAX_WORD))
                        begin
                            ctl.append = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            wte_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    ctl.shift      = 1'b1;
                    out_valid_next = 1'b1;
                    char_next      = head_char;
                    last_next      = (rem_reg == CW'(1));
                    trunc_next     = trunc_b_reg;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == CW'(1))
                    begin
                        state_next = wte_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = wte_pkg::ST_IDLE;
            end
        endcase
    end

    assign count     = count_reg;
    assign out_valid = out_valid_reg;
    assign word_char = char_reg;
    assign last_char = last_reg;
    assign truncated = trunc_reg;

    `WTE_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CW'(MAX_WORD), "word length above capacity")
    `WTE_ASSERT_NOW(a_emit_rem, state_reg == wte_pkg::ST_EMIT, rem_reg != '0, "emit with nothing left")
    `WTE_ASSERT_NOW(a_emit_empty, state_reg == wte_pkg::ST_EMIT, count_reg == '0, "buffer not cleared during emit")
    `WTE_ASSERT_NOW(a_mid_emit, out_valid_reg && !last_reg, state_reg == wte_pkg::ST_EMIT, "mid-word char outside emit")

endmodule

// ----- hdl/word_token_extractor.sv -----
// Top level of the word token extractor: cell chain plus sequencer.
//
// Input channel (in_valid/in_ready, in_byte, end_of_input): one byte per
// accepted byte. Letters are folded to lower case and, with apostrophes,
// appended to a row of MAX_WORD character cells. Digits, control codes,
// DEL and bytes 0x80-0xFF drop the partial word. White space and other
// punctuation end the word; end_of_input does the same and ignores in_byte.
// Output channel (out_valid/out_ready, word_char, last_char, truncated):
// one character per transfer, last_char on the final one, truncated on every
// character of a word that lost letters past MAX_WORD.
// Throughput: letters, discards and empty word ends never block the input.
// A word end with W stored characters moves the sequencer to its emit
// state, in which the cell row shifts one character per cycle toward the
// head into the output register while that register is free; input is
// not taken during that burst. The first character is loaded in emit.
// A stalled receiver holds the output register and pauses the shift; input
// stays blocked until the last character is loaded, and bytes are accepted
// again while that last character waits.
// Reset clears the word length, the overflow flag and the output valid;
// the cell contents need no reset.
module word_token_extractor #(
    parameter int MAX_WORD = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] word_char,
    output logic       last_char,
    output logic       truncated
);

    localparam int CW = $clog2(MAX_WORD + 1);

    wte_pkg::chain_ctl_t ctl;
    logic [CW-1:0]       count;
    logic [7:0]          cell_char [MAX_WORD];

    // Cell 0 is the head; every cell but the last takes its right neighbor on a shift.
    for (genvar i = 0; i < MAX_WORD; i++)
    begin : g_cell
        logic [7:0] nb_char;
        if (i == MAX_WORD - 1)
        begin : g_tail
            assign nb_char = cell_char[i];
        end
        else
        begin : g_mid
            assign nb_char = cell_char[i+1];
        end

        wte_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .count   (count),
            .nb_char (nb_char),
            .char_q  (cell_char[i])
        );
    end

    wte_ctrl #(
        .MAX_WORD (MAX_WORD),
        .CW       (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .head_char    (cell_char[0]),
        .ctl          (ctl),
        .count        (count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .word_char    (word_char),
        .last_char    (last_char),
        .truncated    (truncated)
    );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the word token extractor: directed and random byte streams.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_WORD    = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;

    // One extracted character as the receiver should see it.
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       trunc;
    } word_char_rec_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       end_of_input;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] word_char;
    logic       last_char;
    logic       truncated;

    // Tokenizer state mirrored by the testbench.
    logic [7:0] word_buf [MAX_WORD];
    int         word_len;
    logic       lost_letters;

    word_char_rec_t pending_chars[$];

    int   fail_count;
    int   bytes_sent;
    int   words_predicted;
    int   trunc_words;
    int   chars_checked;
    int   cycle_count;
    logic idle_on;

    word_token_extractor #(
        .MAX_WORD(MAX_WORD)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_input(end_of_input),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .word_char   (word_char),
        .last_char   (last_char),
        .truncated   (truncated)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // Class of a byte already folded to lower case.
    function automatic wte_pkg::cls_t byte_class(input logic [7:0] c);
        if ((c >= 8'h61 && c <= 8'h7A) || c == wte_pkg::APOSTROPHE)
        begin
            return wte_pkg::CLS_ADD;
        end
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return wte_pkg::CLS_DUMP;
        end
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) || (c >= 8'h21 && c <= 8'h7E))
        begin
            return wte_pkg::CLS_END;
        end
        return wte_pkg::CLS_DUMP;
    endfunction

    // Word end: queue the buffered characters, then clear the word.
    function automatic void emit_word();
        word_char_rec_t rec;
        for (int k = 0; k < word_len; k++)
        begin
            rec.ch    = word_buf[k];
            rec.last  = (k == word_len - 1);
            rec.trunc = lost_letters;
            pending_chars.push_back(rec);
        end
        if (word_len > 0)
        begin
            words_predicted++;
            if (lost_letters)
            begin
                trunc_words++;
            end
        end
        word_len     = 0;
        lost_letters = 1'b0;
    endfunction

    function automatic void tokenize_byte(input logic [7:0] raw, input logic eoi);
        logic [7:0] c;
        c = to_lower(raw);
        if (eoi)
        begin
            emit_word();
        end
        else
        begin
            case (byte_class(c))
                wte_pkg::CLS_ADD:
                begin
                    if (word_len < MAX_WORD)
                    begin
                        word_buf[word_len] = c;
                        word_len++;
                    end
                    else
                    begin
                        lost_letters = 1'b1;
                    end
                end
                wte_pkg::CLS_DUMP:
                begin
                    word_len     = 0;
                    lost_letters = 1'b0;
                end
                default:
                begin
                    emit_word();
                end
            endcase
        end
    endfunction

    // ---------------------------------------------------------------
    // Output side: random stall bursts, and the character check
    // ---------------------------------------------------------------

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
            begin
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_word_char
        word_char_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected word_char %h (last_char %b truncated %b)",
                       word_char, last_char, truncated);
                fail_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (word_char !== want.ch)
                begin
                    $error("word_char: expected %h, got %h", want.ch, word_char);
                    fail_count++;
                end
                if (last_char !== want.last)
                begin
                    $error("last_char: expected %b, got %b", want.last, last_char);
                    fail_count++;
                end
                if (truncated !== want.trunc)
                begin
                    $error("truncated: expected %b, got %b", want.trunc, truncated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d characters outstanding",
                 cycle_count, pending_chars.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Send one byte; valid stays up afterwards until the next call or a pause.
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        tokenize_byte(b, eoi);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], 1'b0);
        end
    endtask

    // Random letters in both cases, with an occasional apostrophe.
    task automatic send_letters(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                b = wte_pkg::APOSTROPHE;
            end
            else
            begin
                b = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
            end
            send_byte(b, 1'b0);
        end
    endtask

    function automatic logic [7:0] pick_delimiter();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(0, 127));
        end
        while (byte_class(to_lower(b)) != wte_pkg::CLS_END);
        return b;
    endfunction

    function automatic logic [7:0] pick_discard();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(0, 255));
        end
        while (byte_class(to_lower(b)) != wte_pkg::CLS_DUMP);
        return b;
    endfunction

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_words_out();
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Mixed case folding, space and punctuation ending words.
    task automatic test_plain_words();
        send_text("Hi ZOOM.");
    endtask

    // Byte extremes, discards, apostrophe-only word, empty word ends,
    // 0xFF as data and end of input with and without a pending word.
    task automatic test_byte_classes();
        send_byte(8'h00, 1'b0);
        send_text("ab");
        send_byte(8'hFF, 1'b0);          // drops "ab"
        send_text("c");
        send_byte(8'h7F, 1'b0);          // drops "c"
        send_text("''");
        send_byte(8'h09, 1'b0);          // word of apostrophes only
        send_byte(8'h20, 1'b0);          // nothing buffered
        send_text("x7");                 // digit drops the word
        send_text("q~");
        send_text("!z");
        send_byte(8'hFF, 1'b1);          // flush "z", byte ignored
        send_byte(8'h00, 1'b1);          // nothing pending
        send_byte(8'h80, 1'b0);
    endtask

    // Full buffer, overflow, and overflow flag cleared by a discard.
    task automatic test_capacity();
        send_letters(MAX_WORD);
        send_byte(pick_delimiter(), 1'b0);
        send_letters(MAX_WORD + 3);
        send_byte(8'h2C, 1'b0);
        send_letters(MAX_WORD + 8);
        send_byte(8'h35, 1'b0);
        send_text("ok");
        send_byte(8'h00, 1'b1);
    endtask

    // Sender holds off until every buffered character has drained.
    task automatic test_drain_pause();
        send_text("hold");
        send_byte(8'h0A, 1'b0);
        drop_valid();
        wait_words_out();
    endtask

    // Mostly well-formed words with random content; the rest is noise.
    task automatic test_random_text(input int target);
        int stop_at;
        int pick;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_letters($urandom_range(MAX_WORD - 4, MAX_WORD + 8));
                end
                else
                begin
                    send_letters($urandom_range(1, 9));
                end
                pick = $urandom_range(0, 19);
                if (pick < 16)
                begin
                    send_byte(pick_delimiter(), 1'b0);
                end
                else if (pick < 18)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                end
                else
                begin
                    send_byte(pick_discard(), 1'b0);
                end
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_byte         = 8'h00;
        end_of_input    = 1'b0;
        idle_on         = 1'b1;
        word_len        = 0;
        lost_letters    = 1'b0;
        fail_count      = 0;
        bytes_sent      = 0;
        words_predicted = 0;
        trunc_words     = 0;
        chars_checked   = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_plain_words();
        test_byte_classes();
        test_capacity();
        test_drain_pause();
        test_random_text(85);

        // Closing stretch at full rate on both sides.
        idle_on = 1'b0;
        test_random_text(35);

        drop_valid();
        wait_words_out();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d bytes; %0d words (%0d truncated), %0d characters checked",
                 bytes_sent, words_predicted, trunc_words, chars_checked);
        $display("covered all byte classes, full and overflowing words, end of input");
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/wte_pkg.sv
hdl/wte_cell.sv
hdl/wte_ctrl.sv
hdl/word_token_extractor.sv
test/tb_top.sv
